// ===== src/c2e_pkg.sv =====
// shared constants, register map and lookup helpers for the calendar to epoch converter
`timescale 1ns / 1ps
package c2e_pkg;

  localparam int unsigned SecW   = 6;
  localparam int unsigned MinW   = 6;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MdayW  = 5;
  localparam int unsigned MonW   = 7;
  localparam int unsigned YearW  = 12;
  localparam int unsigned EpochW = 35;
  localparam int unsigned ZoneW  = 17;

  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  // register index taken from paddr[2]
  localparam logic REG_ZONE_OFFSET = 1'b0;

  // day count before the first of each month in a common year
  function automatic logic [8:0] month_start(input logic [3:0] month_idx);
    logic [8:0] days;
    case (month_idx)
      4'd0:    days = 9'd0;
      4'd1:    days = 9'd31;
      4'd2:    days = 9'd59;
      4'd3:    days = 9'd90;
      4'd4:    days = 9'd120;
      4'd5:    days = 9'd151;
      4'd6:    days = 9'd181;
      4'd7:    days = 9'd212;
      4'd8:    days = 9'd243;
      4'd9:    days = 9'd273;
      4'd10:   days = 9'd304;
      4'd11:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

// ===== src/c2e_if.sv =====
// valid/ready channel interfaces for calendar items in and epoch items out
`timescale 1ns / 1ps
interface c2e_in_if;
  import c2e_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [SecW-1:0]          second_of_minute;
  logic [MinW-1:0]          minute_of_hour;
  logic [HourW-1:0]         hour_of_day;
  logic [MdayW-1:0]         day_of_month;
  logic signed [MonW-1:0]   month_number;
  logic [YearW-1:0]         full_year;

  modport source (
    output valid, second_of_minute, minute_of_hour, hour_of_day, day_of_month,
           month_number, full_year,
    input  ready
  );
  modport sink (
    input  valid, second_of_minute, minute_of_hour, hour_of_day, day_of_month,
           month_number, full_year,
    output ready
  );
endinterface

interface c2e_out_if;
  import c2e_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [EpochW-1:0] epoch_seconds;

  modport source (output valid, epoch_seconds, input ready);
  modport sink (input valid, epoch_seconds, output ready);
endinterface

// ===== src/c2e_apb_regs.sv =====
// apb register file holding the zone offset
`timescale 1ns / 1ps
module c2e_apb_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [c2e_pkg::ApbAddrW-1:0]          paddr,
  input  logic [c2e_pkg::ApbDataW-1:0]          pwdata,
  output logic [c2e_pkg::ApbDataW-1:0]          prdata,
  output logic                                  pready,
  output logic signed [c2e_pkg::ZoneW-1:0]      zone_offset_o
);
  import c2e_pkg::*;

  logic signed [ZoneW-1:0] zone_q;
  logic signed [ZoneW-1:0] zone_d;
  logic                    reg_idx;
  logic                    wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && (reg_idx == REG_ZONE_OFFSET);

  always_comb begin
    zone_d = zone_q;
    if (wr_en) begin
      zone_d = pwdata[ZoneW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= '0;
    end else begin
      zone_q <= zone_d;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ZONE_OFFSET: prdata = {{(ApbDataW-ZoneW){zone_q[ZoneW-1]}}, zone_q};
      default:         prdata = '0;
    endcase
  end

  assign zone_offset_o = zone_q;

endmodule

// ===== src/calendar_to_epoch_seconds_unit.sv =====
// calendar time to epoch seconds converter: seven stage pipeline
//
//   channel   dir   handshake        payload
//   din_i     in    valid/ready      sec, min, hour, mday, month, year
//   dout_o    out   valid/ready      epoch_seconds
//   apb       in    psel/penable     zone_offset_seconds at byte address 0
//
// each accepted item passes through every stage register in order; one item can
// enter per cycle while the output is not stalled. the stages are month fold, leap counts
// and constant products, day sum, hours, minutes, seconds plus zone, clamp.
// each stage holds its own valid bit and is ready when empty or when the stage
// after it moves, so bubbles close up under a stalled output.
// reset clears the valid bits and the zone offset to zero.
`timescale 1ns / 1ps
module calendar_to_epoch_seconds_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  c2e_in_if.sink                                din_i,
  c2e_out_if.source                             dout_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [c2e_pkg::ApbAddrW-1:0]          paddr,
  input  logic [c2e_pkg::ApbDataW-1:0]          pwdata,
  output logic [c2e_pkg::ApbDataW-1:0]          prdata,
  output logic                                  pready
);
  import c2e_pkg::*;

  localparam int unsigned NumStages = 7;
  localparam logic [15:0] Recip12   = 16'd171;   // 2^11 / 12, rounded up
  localparam logic [24:0] Recip100  = 25'd5243;  // 2^19 / 100, rounded up
  localparam logic signed [EpochW-1:0] EpochMax = {1'b0, {(EpochW-1){1'b1}}};

  logic signed [ZoneW-1:0] zone_offset;

  c2e_apb_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .zone_offset_o (zone_offset)
  );

  // stage flow control
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] v_d;
  logic [NumStages:0]   en;

  always_comb begin
    en[NumStages] = dout_o.ready;
    for (int k = NumStages - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < NumStages; k++) begin
      if (k == 0) begin
        v_d[k] = en[k] ? din_i.valid : v_q[k];
      end else begin
        v_d[k] = en[k] ? v_q[k-1] : v_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign din_i.ready = en[0];

  // stage 1: fold month into 0..11 with floor division of (month - 1) by 12
  logic [8:0]              fold_sum;
  logic [7:0]              fold_u;
  logic [15:0]             fold_prod;
  logic [3:0]              fold_q;
  logic [7:0]              fold_rem;
  logic signed [13:0]      year_sum;

  always_comb begin
    fold_sum  = $signed({{2{din_i.month_number[MonW-1]}}, din_i.month_number}) + 9'sd71;
    fold_u    = fold_sum[7:0];
    fold_prod = {8'd0, fold_u} * Recip12;
    fold_q    = fold_prod[14:11];
    fold_rem  = fold_u - {1'b0, fold_q, 3'b000} - {2'b00, fold_q, 2'b00};
    // years since 1900 plus the carry, less the bias of six folded into fold_u
    year_sum  = $signed({2'b00, din_i.full_year}) + $signed({10'd0, fold_q}) - 14'sd1906;
  end

  logic [3:0]              s1_month_q;
  logic signed [12:0]      s1_year_q;
  logic [MdayW-1:0]        s1_mday_q;
  logic [HourW-1:0]        s1_hour_q;
  logic [MinW-1:0]         s1_min_q;
  logic [SecW-1:0]         s1_sec_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_month_q <= fold_rem[3:0];
      s1_year_q  <= year_sum[12:0];
      s1_mday_q  <= din_i.day_of_month;
      s1_hour_q  <= din_i.hour_of_day;
      s1_min_q   <= din_i.minute_of_hour;
      s1_sec_q   <= din_i.second_of_minute;
    end
  end

  // stage 2: leap day terms and constant products
  logic signed [12:0]      leap_sum;
  logic [11:0]             lyr;
  logic [11:0]             lyr_m69;
  logic [11:0]             lyr_m1;
  logic [11:0]             lyr_p299;
  logic [24:0]             p100;
  logic [24:0]             p400;
  logic signed [12:0]      yrel;
  logic signed [21:0]      y365;
  logic signed [9:0]       base;
  logic                    year_neg;

  always_comb begin
    leap_sum = s1_year_q + $signed({12'd0, (s1_month_q > 4'd1)});
    lyr      = leap_sum[11:0];
    // before 1969 every total is negative, so only the flag matters there
    year_neg = s1_year_q < 13'sd69;
    lyr_m69  = lyr - 12'd69;
    lyr_m1   = lyr - 12'd1;
    lyr_p299 = lyr + 12'd299;
    p100     = {13'd0, lyr_m1} * Recip100;
    p400     = {15'd0, lyr_p299[11:2]} * Recip100;
    yrel     = s1_year_q - 13'sd70;
    y365     = $signed({{9{yrel[12]}}, yrel}) * 22'sd365;
    base     = $signed({1'b0, month_start(s1_month_q)}) + $signed({5'd0, s1_mday_q}) - 10'sd1;
  end

  logic signed [21:0]      s2_y365_q;
  logic signed [9:0]       s2_base_q;
  logic [9:0]              s2_t4_q;
  logic [5:0]              s2_q100_q;
  logic [3:0]              s2_q400_q;
  logic                    s2_neg_q;
  logic [HourW-1:0]        s2_hour_q;
  logic [MinW-1:0]         s2_min_q;
  logic [SecW-1:0]         s2_sec_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_y365_q <= y365;
      s2_base_q <= base;
      s2_t4_q   <= lyr_m69[11:2];
      s2_q100_q <= p100[24:19];
      s2_q400_q <= p400[22:19];
      s2_neg_q  <= year_neg;
      s2_hour_q <= s1_hour_q;
      s2_min_q  <= s1_min_q;
      s2_sec_q  <= s1_sec_q;
    end
  end

  // stage 3: day count
  logic signed [21:0]      days;

  always_comb begin
    days = s2_y365_q
         + $signed({{12{s2_base_q[9]}}, s2_base_q})
         + $signed({12'd0, s2_t4_q})
         - $signed({16'd0, s2_q100_q})
         + $signed({18'd0, s2_q400_q});
  end

  logic signed [21:0]      s3_days_q;
  logic                    s3_neg_q;
  logic [HourW-1:0]        s3_hour_q;
  logic [MinW-1:0]         s3_min_q;
  logic [SecW-1:0]         s3_sec_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_days_q <= days;
      s3_neg_q  <= s2_neg_q;
      s3_hour_q <= s2_hour_q;
      s3_min_q  <= s2_min_q;
      s3_sec_q  <= s2_sec_q;
    end
  end

  // stage 4: hours
  logic signed [26:0]      hrs;

  always_comb begin
    hrs = $signed({{5{s3_days_q[21]}}, s3_days_q}) * 27'sd24 + $signed({22'd0, s3_hour_q});
  end

  logic signed [26:0]      s4_hrs_q;
  logic                    s4_neg_q;
  logic [MinW-1:0]         s4_min_q;
  logic [SecW-1:0]         s4_sec_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_hrs_q <= hrs;
      s4_neg_q <= s3_neg_q;
      s4_min_q <= s3_min_q;
      s4_sec_q <= s3_sec_q;
    end
  end

  // stage 5: minutes
  logic signed [32:0]      mins;

  always_comb begin
    mins = $signed({{6{s4_hrs_q[26]}}, s4_hrs_q}) * 33'sd60 + $signed({27'd0, s4_min_q});
  end

  logic signed [32:0]      s5_mins_q;
  logic                    s5_neg_q;
  logic [SecW-1:0]         s5_sec_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_mins_q <= mins;
      s5_neg_q  <= s4_neg_q;
      s5_sec_q  <= s4_sec_q;
    end
  end

  // stage 6: seconds plus zone offset
  logic signed [38:0]      tot;

  always_comb begin
    tot = $signed({{6{s5_mins_q[32]}}, s5_mins_q}) * 39'sd60
        + $signed({33'd0, s5_sec_q})
        + $signed({{(39-ZoneW){zone_offset[ZoneW-1]}}, zone_offset});
  end

  logic signed [38:0]      s6_tot_q;
  logic                    s6_neg_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_tot_q <= tot;
      s6_neg_q <= s5_neg_q;
    end
  end

  // stage 7: clamp into the output register
  logic signed [EpochW-1:0] epoch_d;
  logic signed [EpochW-1:0] epoch_q;

  always_comb begin
    if (s6_neg_q || s6_tot_q[38]) begin
      epoch_d = '1;
    end else if (s6_tot_q[37:EpochW-1] != '0) begin
      epoch_d = EpochMax;
    end else begin
      epoch_d = s6_tot_q[EpochW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      epoch_q <= epoch_d;
    end
  end

  assign dout_o.valid         = v_q[NumStages-1];
  assign dout_o.epoch_seconds = epoch_q;

endmodule
